FILE: design/btb2l_pkg.sv
// shared types and constants for the two-level branch predictor
package btb2l_pkg;

  localparam int PC_W  = 32;
  localparam int TAG_W = 30;
  localparam int TAG_MAX = 30;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  localparam int BIB_W = 3;
  localparam int HB_W  = 4;
  localparam int TB_W  = 5;
  localparam int SM_W  = 2;

  // entry index before reduction covers every btb_index_bits value
  localparam int RAW_IDX_W = (1 << BIB_W) - 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_BTB_INDEX_BITS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_BITS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAG_BITS       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_HISTORY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_TABLE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHARE_MODE     = 3'd5;

  localparam logic [BIB_W-1:0] BIB_RESET = 3'd4;
  localparam logic [HB_W-1:0]  HB_RESET  = 4'd8;
  localparam logic [TB_W-1:0]  TB_RESET  = 5'd30;

  localparam logic [SM_W-1:0] SHARE_PLAIN = 2'd0;
  localparam logic [SM_W-1:0] SHARE_PC2   = 2'd1;
  localparam logic [SM_W-1:0] SHARE_PC16  = 2'd2;

  localparam logic [1:0] CTR_RESET = 2'b01;
  localparam logic [1:0] CTR_MAX   = 2'b11;
  localparam logic [1:0] CTR_MIN   = 2'b00;

  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 104;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CTR,
    ST_UPD
  } state_e;

endpackage

FILE: design/btb2l_ram.sv
// generic single-write, single-read ram with registered read data
module btb2l_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/btb_two_level_branch_predictor_top.sv
// top level of the branch target buffer with two-level direction prediction
//
// input channel s_axis: one transaction is a predict request (tuser 0) or a
// resolved branch update (tuser 1). output channel m_axis: exactly one result
// transaction per input transaction, in order.
// the accepting edge reads the entry ram into its output register; in ST_CTR the
// counter ram is read (its address depends on the stored history); in ST_UPD the
// result is computed into the output register and, for an update, written back.
// a new item is taken only once the last one has left ST_UPD; the two dependent
// ram reads set this. the output register holds one result, so the next item is
// accepted while a result waits; if the receiver stalls, the item in flight waits
// in its last step and nothing is written until its result can be registered.
// after reset the block sweeps both rams to their reset contents, one word a
// cycle, over (MAX_ENTRIES + 1) * 2**MAX_HISTORY counter addresses (8448 at the
// defaults); s_axis_tready stays low during the sweep. configuration writes on
// cfg_* are to be made by the user only while no item is in flight; the block
// does not enforce this. they apply to items accepted afterwards.
module btb_two_level_branch_predictor_top
  import btb2l_pkg::*;
#(
  parameter int MAX_ENTRIES = 32,
  parameter int MAX_HISTORY = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pc [31:0], target_pc [63:32], taken [64], zero fill
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  // func [0]
  input  logic [S_TUSER_W-1:0]   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // predicted_taken [0], predicted_target [32:1], branch_count [64:33],
  // flush_count [96:65], zero fill
  output logic [M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int HW        = MAX_HISTORY;
  localparam int EW        = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW        = $clog2(MAX_ENTRIES + 1);
  localparam int CAW       = RW + HW;
  localparam int CTR_DEPTH = (MAX_ENTRIES + 1) << HW;
  localparam int ENT_W     = TAG_W + PC_W + HW;
  localparam int TGT_LSB   = TAG_W;
  localparam int HIST_LSB  = TAG_W + PC_W;

  // configuration
  logic [BIB_W-1:0] bib_q;
  logic [HB_W-1:0]  hb_q;
  logic [TB_W-1:0]  tb_q;
  logic             gh_q;
  logic             gt_q;
  logic [SM_W-1:0]  sm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bib_q <= BIB_RESET;
      hb_q  <= HB_RESET;
      tb_q  <= TB_RESET;
      gh_q  <= 1'b0;
      gt_q  <= 1'b0;
      sm_q  <= SHARE_PLAIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BTB_INDEX_BITS: bib_q <= cfg_data_i[BIB_W-1:0];
        CFG_HISTORY_BITS:   hb_q  <= cfg_data_i[HB_W-1:0];
        CFG_TAG_BITS:       tb_q  <= cfg_data_i[TB_W-1:0];
        CFG_GLOBAL_HISTORY: gh_q  <= cfg_data_i[0];
        CFG_GLOBAL_TABLE:   gt_q  <= cfg_data_i[0];
        CFG_SHARE_MODE:     sm_q  <= cfg_data_i[SM_W-1:0];
        default: ;
      endcase
    end
  end

  // entry index reduction table
  logic [EW-1:0] mod_tbl [1 << RAW_IDX_W];
  for (genvar g = 0; g < (1 << RAW_IDX_W); g++) begin : g_mod
    assign mod_tbl[g] = EW'(g % MAX_ENTRIES);
  end

  // decoded configuration
  logic [RAW_IDX_W-1:0] idx_mask;
  logic [HB_W-1:0]      hist_len;
  logic [HW-1:0]        hist_mask;
  logic [TB_W-1:0]      tag_len;
  logic [TAG_W-1:0]     tag_mask;

  assign idx_mask  = RAW_IDX_W'((8'd1 << bib_q) - 8'd1);
  assign hist_len  = (hb_q > HB_W'(MAX_HISTORY)) ? HB_W'(MAX_HISTORY) : hb_q;
  assign hist_mask = HW'(((HW + 1)'(1) << hist_len) - (HW + 1)'(1));
  assign tag_len   = (tb_q > TB_W'(TAG_MAX)) ? TB_W'(TAG_MAX) : tb_q;
  assign tag_mask  = TAG_W'((31'd1 << tag_len) - 31'd1);

  // input unpack
  logic [PC_W-1:0] in_pc;
  logic [PC_W-1:0] in_tgt;
  logic            in_tk;
  logic            in_func;
  logic [EW-1:0]   in_entry;

  assign in_pc    = s_axis_tdata[PC_W-1:0];
  assign in_tgt   = s_axis_tdata[2*PC_W-1:PC_W];
  assign in_tk    = s_axis_tdata[2*PC_W];
  assign in_func  = s_axis_tuser[0];
  assign in_entry = mod_tbl[in_pc[2 +: RAW_IDX_W] & idx_mask];

  // control
  state_e          state_q, state_d;
  logic            clr_q;
  logic [CAW-1:0]  clr_addr_q;
  logic            s_accept;
  logic            out_free;
  logic            upd_fire;
  logic            m_valid_q;
  logic [HW-1:0]   shared_hist_q;

  // item in flight
  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] tgt_q;
  logic            tk_q;
  logic            func_q;
  logic [EW-1:0]   entry_q;
  logic [CAW-1:0]  ctr_addr_q, ctr_addr_d;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    upd_fire      = 1'b0;
    out_free      = !m_valid_q || m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = !clr_q;
        if (s_axis_tvalid && !clr_q) begin
          state_d = ST_CTR;
        end
      end
      ST_CTR: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          upd_fire = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + CAW'(1);
        if (clr_addr_q == CAW'(CTR_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pc_q    <= in_pc;
      tgt_q   <= in_tgt;
      tk_q    <= in_tk;
      func_q  <= in_func;
      entry_q <= in_entry;
    end
    if (state_q == ST_CTR) begin
      ctr_addr_q <= ctr_addr_d;
    end
  end

  // entry ram
  logic             ent_we;
  logic [EW-1:0]    ent_waddr;
  logic [ENT_W-1:0] ent_wdata;
  logic [ENT_W-1:0] ent_rdata;
  logic [TAG_W-1:0] ent_tag;
  logic [PC_W-1:0]  ent_target;
  logic [HW-1:0]    ent_hist;

  assign ent_tag    = ent_rdata[TAG_W-1:0];
  assign ent_target = ent_rdata[TGT_LSB +: PC_W];
  assign ent_hist   = ent_rdata[HIST_LSB +: HW];

  // counter ram
  logic            ctr_we;
  logic [CAW-1:0]  ctr_waddr;
  logic [1:0]      ctr_wdata;
  logic [1:0]      ctr_rdata;

  // counter address from the stored history
  logic [HW-1:0] hist_sel;
  logic [HW-1:0] ctr_idx;
  logic [RW-1:0] ctr_row;

  always_comb begin
    hist_sel = gh_q ? shared_hist_q : ent_hist;
    ctr_idx  = hist_sel & hist_mask;
    case (sm_q)
      SHARE_PC2:  ctr_idx = ctr_idx ^ (pc_q[2 +: HW] & hist_mask);
      SHARE_PC16: ctr_idx = ctr_idx ^ (pc_q[16 +: HW] & hist_mask);
      default: ;
    endcase
    ctr_row    = gt_q ? RW'(MAX_ENTRIES) : RW'(entry_q);
    ctr_addr_d = {ctr_row, ctr_idx};
  end

  // result and training
  logic [PC_W-1:0]  branches_q, branches_d;
  logic [PC_W-1:0]  flushes_q, flushes_d;
  logic [TAG_W-1:0] pc_tag;
  logic [HW-1:0]    hist_old;
  logic [HW-1:0]    hist_new;
  logic [1:0]       ctr_new;
  logic             pred_tk;
  logic [PC_W-1:0]  pred_tgt;

  always_comb begin
    pc_tag     = pc_q[2 +: TAG_W] & tag_mask;
    hist_old   = gh_q ? shared_hist_q : ent_hist;
    hist_new   = HW'({hist_old, tk_q}) & hist_mask;
    branches_d = branches_q;
    flushes_d  = flushes_q;
    pred_tk    = 1'b0;
    pred_tgt   = '0;
    ctr_new    = ctr_rdata;
    if (func_q == FUNC_PREDICT) begin
      if (ent_tag == pc_tag && ctr_rdata[1]) begin
        pred_tk  = 1'b1;
        pred_tgt = ent_target;
      end else begin
        pred_tgt = pc_q + PC_W'(4);
      end
    end else begin
      branches_d = branches_q + PC_W'(1);
      if (ctr_rdata[1] != tk_q) begin
        flushes_d = flushes_q + PC_W'(1);
      end
      if (tk_q) begin
        if (ctr_rdata != CTR_MAX) ctr_new = ctr_rdata + 2'd1;
      end else begin
        if (ctr_rdata != CTR_MIN) ctr_new = ctr_rdata - 2'd1;
      end
    end
  end

  logic upd_write;
  assign upd_write = upd_fire && (func_q == FUNC_UPDATE);

  always_comb begin
    if (clr_q) begin
      ent_we    = clr_addr_q < CAW'(MAX_ENTRIES);
      ent_waddr = clr_addr_q[EW-1:0];
      ent_wdata = '0;
      ctr_we    = 1'b1;
      ctr_waddr = clr_addr_q;
      ctr_wdata = CTR_RESET;
    end else begin
      ent_we    = upd_write;
      ent_waddr = entry_q;
      ent_wdata = {(gh_q ? ent_hist : hist_new), tgt_q, pc_tag};
      ctr_we    = upd_write;
      ctr_waddr = ctr_addr_q;
      ctr_wdata = ctr_new;
    end
  end

  btb2l_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (s_accept),
    .raddr_i(in_entry),
    .rdata_o(ent_rdata)
  );

  btb2l_ram #(
    .WIDTH(2),
    .DEPTH(CTR_DEPTH)
  ) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (ctr_we),
    .waddr_i(ctr_waddr),
    .wdata_i(ctr_wdata),
    .re_i   (state_q == ST_CTR),
    .raddr_i(ctr_addr_d),
    .rdata_o(ctr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_hist_q <= '0;
      branches_q    <= '0;
      flushes_q     <= '0;
    end else if (upd_fire) begin
      branches_q <= branches_d;
      flushes_q  <= flushes_d;
      if (func_q == FUNC_UPDATE && gh_q) begin
        shared_hist_q <= hist_new;
      end
    end
  end

  // output register
  logic [M_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (upd_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      m_data_q <= M_TDATA_W'({flushes_d, branches_d, pred_tgt, pred_tk});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_accept_reads_ctr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == ST_CTR)
    else $error("accepted item did not move to the counter read");

  a_ctr_then_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CTR |=> state_q == ST_UPD)
    else $error("counter read not followed by the update step");

  a_fire_shows_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> m_valid_q)
    else $error("finished item left no result");

  a_count_only_on_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_write |=> $stable(branches_q))
    else $error("branch count moved without an update");

  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(state_q == ST_CTR || state_q == ST_UPD))
    else $error("item in flight during the reset sweep");

endmodule
